@@ src/rpc_pkg.sv @@
// Shared types, constants and the arctangent table of the rectangular/polar converter.
package rpc_pkg;

   // Operation select carried with every transaction
   typedef enum logic {
      OP_TO_POLAR = 1'b0,
      OP_TO_RECT  = 1'b1
   } opcode_type;

   // Control that travels down the pipeline beside the datapath
   typedef struct packed {
      logic       valid;
      opcode_type op;
      logic       zero;
   } rpc_ctl_type;

   localparam int GUARD_BITS       = 16;
   localparam int ANGLE_BITS       = 16;
   localparam int MAG_IN_WIDTH     = 15;
   localparam int Z_WIDTH          = 32;
   localparam int ATAN_INDEX_WIDTH = 5;

   // 1/K in Q0.32, K being the limit CORDIC gain
   localparam logic [31:0]        GAIN_Q32     = 32'h9B74EDA8;
   localparam logic [Z_WIDTH-1:0] HALF_TURN    = 32'h80000000;
   localparam logic [Z_WIDTH-1:0] QUARTER_TURN = 32'h40000000;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [Z_WIDTH-1:0] atan_turn(input logic [ATAN_INDEX_WIDTH-1:0] idx);
      logic [Z_WIDTH-1:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051E;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2F;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2FA;
         5'd15:   r = 32'h0000517D;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A30;
         5'd19:   r = 32'h00000518;
         5'd20:   r = 32'h0000028C;
         5'd21:   r = 32'h00000146;
         5'd22:   r = 32'h000000A3;
         5'd23:   r = 32'h00000051;
         5'd24:   r = 32'h00000029;
         5'd25:   r = 32'h00000014;
         5'd26:   r = 32'h0000000A;
         5'd27:   r = 32'h00000005;
         5'd28:   r = 32'h00000003;
         5'd29:   r = 32'h00000001;
         5'd30:   r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

@@ src/rpc_if.sv @@
// Request and response channel interfaces of the rectangular/polar converter.
interface rpc_req_if #(parameter int DATA_WIDTH = 16);
   import rpc_pkg::*;

   logic                         valid;
   logic                         ready;
   opcode_type                   opcode;
   logic signed [DATA_WIDTH-1:0] x_in;
   logic signed [DATA_WIDTH-1:0] y_in;
   logic [MAG_IN_WIDTH-1:0]      magnitude_in;
   logic [ANGLE_BITS-1:0]        angle_in;

   modport source (output valid, opcode, x_in, y_in, magnitude_in, angle_in, input ready);
   modport sink   (input valid, opcode, x_in, y_in, magnitude_in, angle_in, output ready);
endinterface

interface rpc_rsp_if #(parameter int DATA_WIDTH = 16);
   import rpc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] x_out;
   logic signed [DATA_WIDTH-1:0] y_out;
   logic [DATA_WIDTH-1:0]        magnitude_out;
   logic [ANGLE_BITS-1:0]        angle_out;

   modport source (output valid, x_out, y_out, magnitude_out, angle_out, input ready);
   modport sink   (input valid, x_out, y_out, magnitude_out, angle_out, output ready);
endinterface

@@ src/rpc_stage.sv @@
// One registered CORDIC micro-rotation, vectoring or rotation mode per transaction.
module rpc_stage #(
   parameter int XW    = 36,
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  rpc_pkg::rpc_ctl_type ctl_prev,
   input  logic signed [XW-1:0] x_prev,
   input  logic signed [XW-1:0] y_prev,
   input  logic [31:0]          z_prev,
   output rpc_pkg::rpc_ctl_type ctl_ff,
   output logic signed [XW-1:0] x_ff,
   output logic signed [XW-1:0] y_ff,
   output logic [31:0]          z_ff
);
   import rpc_pkg::*;

   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic [Z_WIDTH-1:0]   step;
   logic                 cw;
   logic signed [XW-1:0] x_in;
   logic signed [XW-1:0] y_in;
   logic [Z_WIDTH-1:0]   z_in;

   // Direction: drive y to zero when vectoring, z to zero when rotating
   always_comb begin
      xs   = x_prev >>> SHIFT;
      ys   = y_prev >>> SHIFT;
      step = atan_turn(ATAN_INDEX_WIDTH'(SHIFT));
      if (ctl_prev.op == OP_TO_POLAR) begin
         cw = !y_prev[XW-1];
      end else begin
         cw = z_prev[Z_WIDTH-1];
      end
      if (cw) begin
         x_in = x_prev + ys;
         y_in = y_prev - xs;
         z_in = z_prev + step;
      end else begin
         x_in = x_prev - ys;
         y_in = y_prev + xs;
         z_in = z_prev - step;
      end
   end

   // Control register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff <= ctl_prev;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

@@ src/rect_polar_converter.sv @@
// Rectangular/polar converter top level: CORDIC pipeline with gain removal and saturation.
// A request passes the input register, one registered CORDIC stage per iteration, then the
// magnitude, multiply and response registers; one transaction per cycle unless stalled.
// The whole pipeline advances together; a stalled response holds every stage in place.
// Reset (synchronous) clears all valid bits and holds request ready low; datapath not reset.
module rect_polar_converter #(
   parameter int ITERATIONS = 16,
   parameter int DATA_WIDTH = 16
) (
   input logic    clock,
   input logic    reset,
   rpc_req_if.sink   req_if,
   rpc_rsp_if.source rsp_if
);
   import rpc_pkg::*;

   localparam int NARROW     = (DATA_WIDTH > MAG_IN_WIDTH) ? DATA_WIDTH : MAG_IN_WIDTH;
   localparam int XW         = NARROW + GUARD_BITS + 4;
   localparam int RW         = XW + 1 - GUARD_BITS;
   localparam int PASS_DEPTH = ITERATIONS + 3;

   localparam logic [RW-1:0] UMAX = RW'((64'd1 << DATA_WIDTH) - 64'd1);
   localparam logic [RW-1:0] SMAX = RW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic [RW-1:0] SLIM = RW'(64'd1 << (DATA_WIDTH - 1));
   localparam logic [XW:0]   ROUND_HALF = (XW+1)'(64'd1 << (GUARD_BITS - 1));
   localparam logic [Z_WIDTH-1:0] ANGLE_HALF_LSB = Z_WIDTH'(64'd1 << (Z_WIDTH - ANGLE_BITS - 1));

   // Fields that bypass the CORDIC datapath
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] x;
      logic signed [DATA_WIDTH-1:0] y;
      logic [MAG_IN_WIDTH-1:0]      mag;
      logic [ANGLE_BITS-1:0]        ang;
   } pass_type;

   logic advance;

   // Input conditioning stage
   rpc_ctl_type          ctl_p_in, ctl_p_ff;
   logic signed [XW-1:0] x_p_in, x_p_ff;
   logic signed [XW-1:0] y_p_in, y_p_ff;
   logic [Z_WIDTH-1:0]   z_p_in, z_p_ff;
   logic signed [XW-1:0] x_ext, y_ext, m_ext;
   logic [Z_WIDTH-1:0]   z_ang;

   // CORDIC chain
   rpc_ctl_type          ctl_s [0:ITERATIONS];
   logic signed [XW-1:0] x_s   [0:ITERATIONS];
   logic signed [XW-1:0] y_s   [0:ITERATIONS];
   logic [Z_WIDTH-1:0]   z_s   [0:ITERATIONS];

   // Magnitude stage
   rpc_ctl_type           ctl_a_ff;
   logic [XW-1:0]         ax_in, ax_a_ff;
   logic [XW-1:0]         ay_in, ay_a_ff;
   logic                  sx_a_ff, sy_a_ff;
   logic [Z_WIDTH-1:0]    z_round;
   logic [ANGLE_BITS-1:0] ang_a_ff;
   logic signed [XW-1:0]  x_last, y_last;

   // Multiply stage
   rpc_ctl_type           ctl_m_ff;
   logic [63:0]           plx, ply;
   logic [31:0]           tx_m_ff, ty_m_ff;
   logic [XW-1:0]         hx_m_ff, hy_m_ff;
   logic                  sx_m_ff, sy_m_ff;
   logic [ANGLE_BITS-1:0] ang_m_ff;

   // Output stage
   logic [XW:0]                  midx, midy;
   logic [RW-1:0]                rx, ry;
   logic signed [DATA_WIDTH-1:0] x_out_in, y_out_in;
   logic [DATA_WIDTH-1:0]        mag_out_in;
   logic [ANGLE_BITS-1:0]        ang_out_in;
   logic signed [DATA_WIDTH-1:0] sat_x, sat_y;
   logic [DATA_WIDTH-1:0]        sat_mag;
   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] x_out_ff, y_out_ff;
   logic [DATA_WIDTH-1:0]        mag_out_ff;
   logic [ANGLE_BITS-1:0]        ang_out_ff;

   pass_type pass_in;
   pass_type pass_ff [0:PASS_DEPTH-1];

   // Global pipeline enable: move when the output register is free or being taken
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance && !reset;

   // Fold the input into the right half plane and into fixed point
   always_comb begin
      x_ext = XW'(req_if.x_in) <<< GUARD_BITS;
      y_ext = XW'(req_if.y_in) <<< GUARD_BITS;
      m_ext = XW'(req_if.magnitude_in) << GUARD_BITS;
      z_ang = {req_if.angle_in, {(Z_WIDTH - ANGLE_BITS){1'b0}}};

      ctl_p_in.valid = req_if.valid;
      ctl_p_in.op    = req_if.opcode;
      ctl_p_in.zero  = (req_if.x_in == '0) && (req_if.y_in == '0);

      if (req_if.opcode == OP_TO_POLAR) begin
         if (req_if.x_in[DATA_WIDTH-1]) begin
            x_p_in = -x_ext;
            y_p_in = -y_ext;
            z_p_in = HALF_TURN;
         end else begin
            x_p_in = x_ext;
            y_p_in = y_ext;
            z_p_in = '0;
         end
      end else begin
         y_p_in = '0;
         // second and third quadrant: start from -magnitude, angle less a half turn
         if (req_if.angle_in[ANGLE_BITS-1] ^ req_if.angle_in[ANGLE_BITS-2]) begin
            x_p_in = -m_ext;
            z_p_in = z_ang - HALF_TURN;
         end else begin
            x_p_in = m_ext;
            z_p_in = z_ang;
         end
      end

      pass_in.x   = req_if.x_in;
      pass_in.y   = req_if.y_in;
      pass_in.mag = req_if.magnitude_in;
      pass_in.ang = req_if.angle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_p_ff <= ctl_p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_p_ff <= x_p_in;
         y_p_ff <= y_p_in;
         z_p_ff <= z_p_in;
      end
   end

   // Bypass delay line, aligned with the multiply stage
   always_ff @(posedge clock) begin
      if (advance) begin
         pass_ff[0] <= pass_in;
         for (int k = 1; k < PASS_DEPTH; k++) begin
            pass_ff[k] <= pass_ff[k-1];
         end
      end
   end

   // CORDIC iterations
   assign ctl_s[0] = ctl_p_ff;
   assign x_s[0]   = x_p_ff;
   assign y_s[0]   = y_p_ff;
   assign z_s[0]   = z_p_ff;

   for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
      rpc_stage #(
         .XW    (XW),
         .SHIFT (g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .ctl_prev (ctl_s[g]),
         .x_prev   (x_s[g]),
         .y_prev   (y_s[g]),
         .z_prev   (z_s[g]),
         .ctl_ff   (ctl_s[g+1]),
         .x_ff     (x_s[g+1]),
         .y_ff     (y_s[g+1]),
         .z_ff     (z_s[g+1])
      );
   end

   // Absolute values and angle rounding
   always_comb begin
      x_last  = x_s[ITERATIONS];
      y_last  = y_s[ITERATIONS];
      z_round = z_s[ITERATIONS] + ANGLE_HALF_LSB;
      if (!x_last[XW-1]) begin
         ax_in = x_last;
      end else if (ctl_s[ITERATIONS].op == OP_TO_POLAR) begin
         ax_in = '0;
      end else begin
         ax_in = -x_last;
      end
      ay_in = y_last[XW-1] ? -y_last : y_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_a_ff <= ctl_s[ITERATIONS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_a_ff  <= ax_in;
         ay_a_ff  <= ay_in;
         sx_a_ff  <= x_last[XW-1];
         sy_a_ff  <= y_last[XW-1];
         ang_a_ff <= z_round[Z_WIDTH-1 -: ANGLE_BITS];
      end
   end

   // Gain removal: low and high 32-bit partial products
   assign plx = {32'd0, ax_a_ff[31:0]} * {32'd0, GAIN_Q32};
   assign ply = {32'd0, ay_a_ff[31:0]} * {32'd0, GAIN_Q32};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_m_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_m_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tx_m_ff  <= plx[63:32];
         ty_m_ff  <= ply[63:32];
         hx_m_ff  <= XW'(ax_a_ff[XW-1:32]) * XW'(GAIN_Q32);
         hy_m_ff  <= XW'(ay_a_ff[XW-1:32]) * XW'(GAIN_Q32);
         sx_m_ff  <= sx_a_ff;
         sy_m_ff  <= sy_a_ff;
         ang_m_ff <= ang_a_ff;
      end
   end

   // Sum partial products, round half away from zero, saturate, select outputs
   always_comb begin
      midx = (XW+1)'(hx_m_ff) + (XW+1)'(tx_m_ff);
      midy = (XW+1)'(hy_m_ff) + (XW+1)'(ty_m_ff);
      rx   = RW'((midx + ROUND_HALF) >> GUARD_BITS);
      ry   = RW'((midy + ROUND_HALF) >> GUARD_BITS);

      sat_mag = (rx > UMAX) ? UMAX[DATA_WIDTH-1:0] : rx[DATA_WIDTH-1:0];

      if (sx_m_ff) begin
         sat_x = (rx > SLIM) ? (~SLIM[DATA_WIDTH-1:0] + 1'b1) : (~rx[DATA_WIDTH-1:0] + 1'b1);
      end else begin
         sat_x = (rx > SMAX) ? SMAX[DATA_WIDTH-1:0] : rx[DATA_WIDTH-1:0];
      end
      if (sy_m_ff) begin
         sat_y = (ry > SLIM) ? (~SLIM[DATA_WIDTH-1:0] + 1'b1) : (~ry[DATA_WIDTH-1:0] + 1'b1);
      end else begin
         sat_y = (ry > SMAX) ? SMAX[DATA_WIDTH-1:0] : ry[DATA_WIDTH-1:0];
      end

      if (ctl_m_ff.op == OP_TO_POLAR) begin
         x_out_in = pass_ff[PASS_DEPTH-1].x;
         y_out_in = pass_ff[PASS_DEPTH-1].y;
         if (ctl_m_ff.zero) begin
            mag_out_in = '0;
            ang_out_in = '0;
         end else begin
            mag_out_in = sat_mag;
            ang_out_in = ang_m_ff;
         end
      end else begin
         x_out_in   = sat_x;
         y_out_in   = sat_y;
         mag_out_in = DATA_WIDTH'(pass_ff[PASS_DEPTH-1].mag);
         ang_out_in = pass_ff[PASS_DEPTH-1].ang;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl_m_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_out_ff   <= x_out_in;
         y_out_ff   <= y_out_in;
         mag_out_ff <= mag_out_in;
         ang_out_ff <= ang_out_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.x_out         = x_out_ff;
   assign rsp_if.y_out         = y_out_ff;
   assign rsp_if.magnitude_out = mag_out_ff;
   assign rsp_if.angle_out     = ang_out_ff;

endmodule

@@ sim/tb_rect_polar_converter.sv @@
// Self-checking testbench for the rectangular/polar CORDIC converter.
`timescale 1ns / 1ps

module tb_rect_polar_converter;
   import rpc_pkg::*;

   localparam int ITERATIONS      = 16;
   localparam int DATA_WIDTH      = 16;
   localparam int LATENCY         = ITERATIONS + 3;
   localparam int RANDOM_ITEMS    = 1700;
   localparam int BLOCK_ITEMS     = 100;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int WATCHDOG_LIMIT  = 2000;

   // atan(2^-i) in 2^-32 turn units, one entry per CORDIC step
   localparam bit [31:0] ATAN_STEP [0:15] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   typedef struct packed {
      opcode_type              op;
      logic signed [15:0]      x;
      logic signed [15:0]      y;
      logic [MAG_IN_WIDTH-1:0] mag;
      logic [ANGLE_BITS-1:0]   ang;
   } conv_request_type;

   typedef struct packed {
      logic signed [15:0]    x;
      logic signed [15:0]    y;
      logic [15:0]           mag;
      logic [ANGLE_BITS-1:0] ang;
   } conv_result_type;

   // Computes the expected conversion per accepted request and checks responses in order
   class conversion_board;
      conv_result_type pending_results[$];
      int unsigned     n_polar, n_rect, n_checked, n_saturated, n_errors;

      // floor((a * 1/K) / 2^32), then round half up by the guard bits
      function longint unsigned drop_gain(longint unsigned a);
         logic [95:0] p;
         p = 96'(a) * 96'(GAIN_Q32);
         p = (p >> 32) + (96'd1 << (GUARD_BITS - 1));
         return p[GUARD_BITS +: 64];
      endfunction

      // Gain removal of a signed coordinate, magnitude rounded away from zero, saturated
      function logic [15:0] descale(longint v);
         longint unsigned m;
         longint          lim;
         longint          r;
         lim = longint'(1) << (DATA_WIDTH - 1);
         if (v < 0) begin
            m = drop_gain(-v);
            if (m > lim) begin
               n_saturated++;
               r = -lim;
            end else begin
               r = -longint'(m);
            end
         end else begin
            m = drop_gain(v);
            if (m > lim - 1) begin
               n_saturated++;
               r = lim - 1;
            end else begin
               r = longint'(m);
            end
         end
         return r[15:0];
      endfunction

      function conv_result_type convert(conv_request_type r);
         conv_result_type o;
         longint          x, y, xs, ys, zs;
         bit [31:0]       z;
         bit [32:0]       zr;
         longint unsigned m;
         o.x   = r.x;
         o.y   = r.y;
         o.mag = 16'(r.mag);
         o.ang = r.ang;
         if (r.op == OP_TO_POLAR) begin
            n_polar++;
            if (r.x == 0 && r.y == 0) begin
               o.mag = '0;
               o.ang = '0;
               return o;
            end
            x = longint'($signed(r.x));
            y = longint'($signed(r.y));
            z = '0;
            // left half plane: turn by half a turn first
            if (x < 0) begin
               x = -x;
               y = -y;
               z = HALF_TURN;
            end
            x = x <<< GUARD_BITS;
            y = y <<< GUARD_BITS;
            for (int i = 0; i < ITERATIONS; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y >= 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + ATAN_STEP[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - ATAN_STEP[i];
               end
            end
            m = drop_gain(x < 0 ? 0 : x);
            if (m > 64'hFFFF) begin
               n_saturated++;
               m = 64'hFFFF;
            end
            o.mag = m[15:0];
            // round to 16-bit turns; a full turn wraps to zero
            zr = {1'b0, z} + (33'd1 << (31 - ANGLE_BITS));
            o.ang = zr[31 -: ANGLE_BITS];
         end else begin
            n_rect++;
            z = {r.ang, 16'h0000};
            x = longint'(r.mag) <<< GUARD_BITS;
            y = 0;
            // second and third quadrants: start from -magnitude, half a turn back
            if (z >= QUARTER_TURN && z < HALF_TURN + QUARTER_TURN) begin
               x = -x;
               z = z - HALF_TURN;
            end
            zs = longint'($signed(z));
            for (int i = 0; i < ITERATIONS; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (zs >= 0) begin
                  x  = x - ys;
                  y  = y + xs;
                  zs = zs - longint'(ATAN_STEP[i]);
               end else begin
                  x  = x + ys;
                  y  = y - xs;
                  zs = zs + longint'(ATAN_STEP[i]);
               end
            end
            o.x = descale(x);
            o.y = descale(y);
         end
         return o;
      endfunction

      function void note_request(conv_request_type r);
         pending_results.push_back(convert(r));
      endfunction

      function void compare_field(string name, logic signed [16:0] want_v,
                                  logic signed [16:0] got_v);
         if (got_v !== want_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
         end
      endfunction

      function void check_response(conv_result_type got);
         conv_result_type want;
         if (pending_results.size() == 0) begin
            n_errors++;
            $display("%0t: response with no conversion outstanding: x=%0d y=%0d mag=%0d ang=%0d",
                     $time, got.x, got.y, got.mag, got.ang);
            return;
         end
         want = pending_results.pop_front();
         n_checked++;
         compare_field("x_out", want.x, got.x);
         compare_field("y_out", want.y, got.y);
         compare_field("magnitude_out", want.mag, got.mag);
         compare_field("angle_out", want.ang, got.ang);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   bit          steady_source;
   bit          steady_sink;
   bit          hold_off_req;
   int unsigned idle_cycles;

   conversion_board board = new();

   rpc_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
   rpc_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

   rect_polar_converter #(
      .ITERATIONS(ITERATIONS),
      .DATA_WIDTH(DATA_WIDTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(0, 4))
         0: return 16'($signed($urandom_range(0, 32)) - 16);
         1: begin
            case ($urandom_range(0, 5))
               0: return -16'sd32768;
               1: return -16'sd32767;
               2: return -16'sd1;
               3: return 16'sd0;
               4: return 16'sd1;
               default: return 16'sd32767;
            endcase
         end
         2: return $urandom_range(0, 1) ? 16'($urandom_range(32700, 32767))
                                        : 16'(-$signed($urandom_range(32700, 32768)));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic conv_request_type make_random_request();
      conv_request_type r;
      r.op = opcode_type'($urandom_range(0, 1));
      r.x  = pick_coord();
      case ($urandom_range(0, 5))
         0: r.y = '0;
         1: begin
            r.y = r.x;
            r.x = '0;
         end
         2: r.y = $urandom_range(0, 1) ? r.x : -r.x;
         default: r.y = pick_coord();
      endcase
      case ($urandom_range(0, 4))
         0: r.mag = '1;
         1: r.mag = MAG_IN_WIDTH'($urandom_range(0, 15));
         2: r.mag = MAG_IN_WIDTH'($urandom_range(32700, 32767));
         default: r.mag = MAG_IN_WIDTH'($urandom());
      endcase
      // near the octant boundaries or anywhere
      if ($urandom_range(0, 2) == 0)
         r.ang = ANGLE_BITS'(($urandom_range(0, 7) << 13) + $urandom_range(0, 6) - 3);
      else
         r.ang = ANGLE_BITS'($urandom());
      return r;
   endfunction

   // Offer one transaction at the falling edge and hold it until accepted
   task automatic send_request(conv_request_type r);
      int gap;
      gap = steady_source ? 0 : idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid        = 1'b1;
      req_ch.opcode       = r.op;
      req_ch.x_in         = r.x;
      req_ch.y_in         = r.y;
      req_ch.magnitude_in = r.mag;
      req_ch.angle_in     = r.ang;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_polar(int x, int y);
      conv_request_type r;
      r     = make_random_request();
      r.op  = OP_TO_POLAR;
      r.x   = 16'(x);
      r.y   = 16'(y);
      send_request(r);
   endtask

   task automatic send_rect(int m, int a);
      conv_request_type r;
      r     = make_random_request();
      r.op  = OP_TO_RECT;
      r.mag = MAG_IN_WIDTH'(m);
      r.ang = ANGLE_BITS'(a);
      send_request(r);
   endtask

   // Response ready: random stalls, steady stretches, one long hold-off
   initial begin
      int wait_left;
      rsp_ch.ready = 1'b0;
      wait_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (steady_sink) begin
            rsp_ch.ready = 1'b1;
         end else if (wait_left > 0) begin
            rsp_ch.ready = 1'b0;
            wait_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 2) == 0) wait_left = idle_len();
         end
      end
   end

   // Transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_request('{op: req_ch.opcode, x: req_ch.x_in, y: req_ch.y_in,
                                 mag: req_ch.magnitude_in, ang: req_ch.angle_in});
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response('{x: rsp_ch.x_out, y: rsp_ch.y_out,
                                   mag: rsp_ch.magnitude_out, ang: rsp_ch.angle_out});
      end
   end

   // Watchdog: too many cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_rect_polar_converter: errors");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      reset               = 1'b1;
      steady_source       = 1'b0;
      steady_sink         = 1'b0;
      hold_off_req        = 1'b0;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = OP_TO_POLAR;
      req_ch.x_in         = '0;
      req_ch.y_in         = '0;
      req_ch.magnitude_in = '0;
      req_ch.angle_in     = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero vector, axes, corners, left half plane
      send_polar(0, 0);
      send_polar(32767, 0);
      send_polar(-32768, 0);
      send_polar(0, 32767);
      send_polar(0, -32768);
      send_polar(-32768, -32768);
      send_polar(32767, 32767);
      send_polar(-1, 0);
      send_polar(1, -1);
      send_polar(-32768, 32767);
      // directed: quadrant boundaries, saturation, tiny and zero magnitude
      send_rect(0, 0);
      send_rect(32767, 16'h0000);
      send_rect(32767, 16'h4000);
      send_rect(32767, 16'h8000);
      send_rect(32767, 16'hC000);
      send_rect(32767, 16'h3FFF);
      send_rect(32767, 16'hBFFF);
      send_rect(32767, 16'h2000);
      send_rect(1, 16'hFFFF);
      send_rect(0, 16'h1234);

      // random blocks; one with no idling, one with the long receiver hold-off
      for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
         steady_source = (blk == 4) || (blk == 9);
         steady_sink   = (blk == 4);
         if (blk == 9) hold_off_req = 1'b1;
         repeat (BLOCK_ITEMS) send_request(make_random_request());
      end
      steady_source = 1'b0;
      steady_sink   = 1'b0;
      @(negedge clock);
      req_ch.valid = 1'b0;

      // drain, then watch for stray responses
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (board.pending_results.size() != 0) begin
         board.n_errors += board.pending_results.size();
         $display("%0t: %0d expected responses never arrived", $time,
                  board.pending_results.size());
      end

      $display("Checked %0d conversions: %0d rectangular to polar, %0d polar to rectangular.",
               board.n_checked, board.n_polar, board.n_rect);
      $display("Saturated outputs: %0d; receiver held off %0d cycles under a full pipeline.",
               board.n_saturated, HOLD_OFF_CYCLES);
      if (board.n_errors == 0) begin
         $display("tb_rect_polar_converter: clean");
      end else begin
         $display("tb_rect_polar_converter: errors");
      end
      $finish;
   end

endmodule
